// ===== hw/rtl/imgconv3_pkg.sv =====
// shared types and constants of the 3x3 image convolution block
package imgconv3_pkg;

    // configuration register map
    localparam int CFG_ADDR_BITS = 3;
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } cfg_index_t;

    // register field widths
    localparam int CFG_DATA_BITS   = 24;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 16;
    localparam int KROW_REG_BITS   = 24;

    // register reset values
    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET       = 11'd1024;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET      = 16'd768;
    localparam logic [KROW_REG_BITS-1:0]   KROW_TOP_RESET    = 24'h000101;
    localparam logic [KROW_REG_BITS-1:0]   KROW_MIDDLE_RESET = 24'h010201;
    localparam logic [KROW_REG_BITS-1:0]   KROW_BOTTOM_RESET = 24'h010100;

    // coefficients are in eighths
    localparam int FRAC_BITS = 3;

    // item kind on the input tuser
    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_FLUSH = 1'b1
    } mode_t;

    // position of one item relative to the frame border
    typedef struct packed {
        logic has_result;
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } pos_flags_t;

endpackage

// ===== hw/rtl/imgconv3_ram.sv =====
// generic single write port, single read port ram with registered read
module imgconv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/image_convolution_3x3.sv =====
// top level of the streaming 3x3 zero padded image convolution
//
// Grey pixels enter in raster order, one transaction per clock while tready is
// high, and each pixel position of the frame yields one filtered pixel: the nine
// neighbours times nine signed coefficients in eighths, with neighbours outside
// the frame taken as zero, floored by 8 and clamped to the pixel range. The result
// for a pixel comes out image_width+1 input transactions after that pixel, so
// image_width+1 flush transactions (tuser high) must follow the last pixel of a
// frame to drain it; tlast marks the final result of the frame, after which all
// position counters restart. The block takes one transaction every clock while
// the output skid entry is free: the position logic with the line ram read, the
// window shift, the nine multiplies and the final sum each sit in their own
// register stage, and the result then passes through the output register. The
// two line rams are read and written once per transaction; a fill count stands in
// for their reset contents, so there is no clearing pass after reset. A two entry
// output stage lets the input keep flowing while one result waits on the output.
// Configuration registers must be written only while the block is idle.
module image_convolution_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 8
) (
    input  logic clk,
    input  logic rst_n,

    // input stream
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]           s_axis_tdata,  // pixel_in
    input  logic                                      s_axis_tuser,  // mode

    // output stream
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]           m_axis_tdata,  // pixel_out
    output logic                                      m_axis_tlast,  // last_in_frame

    // configuration write port
    input  logic                                      cfg_wr_en,
    input  logic [imgconv3_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [imgconv3_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    localparam int DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);       // column address
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);   // width 1..MAX_WIDTH
    localparam int SEEN_W    = $clog2(MAX_WIDTH + 2);   // counts up to width+1
    localparam int CMP_W     = (WID_W > imgconv3_pkg::WIDTH_REG_BITS) ?
                               WID_W : imgconv3_pkg::WIDTH_REG_BITS;
    localparam int ROW_W     = imgconv3_pkg::HEIGHT_REG_BITS;
    localparam int KROW_W    = 3 * COEF_BITS;
    localparam int PROD_W    = COEF_BITS + PIXEL_BITS + 1;
    localparam int SUM_W     = PROD_W + 4;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [imgconv3_pkg::WIDTH_REG_BITS-1:0]  image_width_reg;
    logic [imgconv3_pkg::HEIGHT_REG_BITS-1:0] image_height_reg;
    logic [imgconv3_pkg::KROW_REG_BITS-1:0]   krow_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= imgconv3_pkg::WIDTH_RESET;
            image_height_reg <= imgconv3_pkg::HEIGHT_RESET;
            krow_reg[0]      <= imgconv3_pkg::KROW_TOP_RESET;
            krow_reg[1]      <= imgconv3_pkg::KROW_MIDDLE_RESET;
            krow_reg[2]      <= imgconv3_pkg::KROW_BOTTOM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                imgconv3_pkg::CFG_IMAGE_WIDTH:
                    image_width_reg <= cfg_wdata[imgconv3_pkg::WIDTH_REG_BITS-1:0];
                imgconv3_pkg::CFG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_wdata[imgconv3_pkg::HEIGHT_REG_BITS-1:0];
                imgconv3_pkg::CFG_KERNEL_TOP:
                    krow_reg[0] <= cfg_wdata[imgconv3_pkg::KROW_REG_BITS-1:0];
                imgconv3_pkg::CFG_KERNEL_MIDDLE:
                    krow_reg[1] <= cfg_wdata[imgconv3_pkg::KROW_REG_BITS-1:0];
                imgconv3_pkg::CFG_KERNEL_BOTTOM:
                    krow_reg[2] <= cfg_wdata[imgconv3_pkg::KROW_REG_BITS-1:0];
                default:
                    ;   // unmapped index, write dropped
            endcase
        end
    end

    // effective frame size: zero width acts as one, wide frames clamp to the rams
    logic [CMP_W-1:0] width_cfg_ext;
    logic [WID_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb
    begin
        width_cfg_ext = CMP_W'(image_width_reg);
        if (width_cfg_ext == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (width_cfg_ext > CMP_W'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(width_cfg_ext);
        end
        h_eff = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;
    end

    // ---------------------------------------------------------------------
    // flow control: every stage moves together unless the output skid is full
    // ---------------------------------------------------------------------
    logic skid_valid_reg;
    logic advance;
    logic accept;

    assign advance       = !skid_valid_reg;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    // ---------------------------------------------------------------------
    // stage 0: position counters, line ram read
    // ---------------------------------------------------------------------
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [SEEN_W-1:0] seen_reg,    seen_next;
    logic [WID_W-1:0]  fill_reg,    fill_next;

    logic [COL_W-1:0]      ic;
    logic [COL_W-1:0]      oc;
    logic [PIXEL_BITS-1:0] pix_in;
    imgconv3_pkg::pos_flags_t pos;

    always_comb
    begin
        pix_in = (imgconv3_pkg::mode_t'(s_axis_tuser) == imgconv3_pkg::MODE_FLUSH) ?
                 '0 : s_axis_tdata[PIXEL_BITS-1:0];

        // a column left past a narrowed width wraps to zero
        ic = (WID_W'(in_col_reg) >= w_eff) ? '0 : in_col_reg;
        oc = (WID_W'(out_col_reg) >= w_eff) ? '0 : out_col_reg;

        in_col_next  = (WID_W'(ic) + WID_W'(1) >= w_eff) ? '0 : ic + COL_W'(1);
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        seen_next    = seen_reg;

        pos.has_result = (seen_reg >= SEEN_W'(w_eff) + SEEN_W'(1));
        pos.top        = (out_row_reg == '0);
        pos.bottom     = (out_row_reg >= h_eff - ROW_W'(1));
        pos.left       = (oc == '0);
        pos.right      = (WID_W'(oc) >= w_eff - WID_W'(1));
        pos.last       = pos.has_result && pos.bottom && pos.right;

        if (!pos.has_result)
        begin
            seen_next = seen_reg + SEEN_W'(1);
        end
        else if (pos.last)
        begin
            // end of frame: every position counter restarts for the next frame
            in_col_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            seen_next    = '0;
        end
        else if (pos.right)
        begin
            out_col_next = '0;
            out_row_next = out_row_reg + ROW_W'(1);
        end
        else
        begin
            out_col_next = oc + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            seen_reg    <= '0;
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            seen_reg    <= seen_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: line ram data, write back, window shift
    // ---------------------------------------------------------------------
    logic                      s1_valid_reg;
    logic [COL_W-1:0]          s1_col_reg;
    logic [PIXEL_BITS-1:0]     s1_pix_reg;
    logic                      s1_mem_ok_reg;   // entry written since reset
    logic                      s1_hit_reg;      // read met a write to the same column
    logic [PIXEL_BITS-1:0]     s1_fwd_upper_reg;
    logic [PIXEL_BITS-1:0]     s1_fwd_lower_reg;
    imgconv3_pkg::pos_flags_t  s1_pos_reg;

    logic [PIXEL_BITS-1:0] upper_rd;
    logic [PIXEL_BITS-1:0] lower_rd;
    logic [PIXEL_BITS-1:0] upper_val;
    logic [PIXEL_BITS-1:0] lower_val;
    logic                  line_wr;

    assign line_wr = advance && s1_valid_reg;

    always_comb
    begin
        if (s1_hit_reg)
        begin
            upper_val = s1_fwd_upper_reg;
            lower_val = s1_fwd_lower_reg;
        end
        else if (s1_mem_ok_reg)
        begin
            upper_val = upper_rd;
            lower_val = lower_rd;
        end
        else
        begin
            upper_val = '0;
            lower_val = '0;
        end
    end

    // row two back; takes over the row one back at the same column
    imgconv3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (s1_col_reg),
        .wr_data (lower_val),
        .rd_en   (accept),
        .rd_addr (ic),
        .rd_data (upper_rd)
    );

    // row one back
    imgconv3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_lower_ram (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (accept),
        .rd_addr (ic),
        .rd_data (lower_rd)
    );

    // columns are written as a prefix from zero, so a count of them marks valid data
    always_comb
    begin
        fill_next = fill_reg;
        if (WID_W'(s1_col_reg) + WID_W'(1) > fill_reg)
        begin
            fill_next = WID_W'(s1_col_reg) + WID_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fill_reg     <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= ic;
            s1_pix_reg       <= pix_in;
            s1_pos_reg       <= pos;
            s1_mem_ok_reg    <= (WID_W'(ic) < fill_reg);
            // single column frames read the entry that is written on this same edge
            s1_hit_reg       <= s1_valid_reg && (s1_col_reg == ic);
            s1_fwd_upper_reg <= lower_val;
            s1_fwd_lower_reg <= s1_pix_reg;
        end
    end

    // 3x3 window, index row*3+col, col 0 oldest
    logic [PIXEL_BITS-1:0] window_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (line_wr)
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_reg[r*3+0] <= window_reg[r*3+1];
                window_reg[r*3+1] <= window_reg[r*3+2];
            end
            window_reg[2] <= upper_val;
            window_reg[5] <= lower_val;
            window_reg[8] <= s1_pix_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: nine products with zero padding at the frame border
    // ---------------------------------------------------------------------
    logic                     s2_valid_reg;
    imgconv3_pkg::pos_flags_t s2_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg && s1_pos_reg.has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_pos_reg <= s1_pos_reg;
        end
    end

    logic [KROW_W-1:0]        krow_ext [3];
    logic signed [PROD_W-1:0] prod     [9];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            krow_ext[r] = KROW_W'(krow_reg[r]);
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && s2_pos_reg.top) || (r == 2 && s2_pos_reg.bottom) ||
                    (c == 0 && s2_pos_reg.left) || (c == 2 && s2_pos_reg.right))
                begin
                    prod[r*3+c] = '0;
                end
                else
                begin
                    prod[r*3+c] = PROD_W'(
                        $signed(krow_ext[r][c*COEF_BITS +: COEF_BITS]) *
                        $signed({1'b0, window_reg[r*3+c]}));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // stage 3: sum, floor by eight, clamp to the pixel range
    // ---------------------------------------------------------------------
    logic                     s3_valid_reg;
    logic                     s3_last_reg;
    logic signed [PROD_W-1:0] s3_prod_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_last_reg <= s2_pos_reg.last;
            for (int i = 0; i < 9; i++)
            begin
                s3_prod_reg[i] <= prod[i];
            end
        end
    end

    logic signed [SUM_W-1:0] sum;
    logic        [SUM_W-1:0] sum_floor;
    logic [PIXEL_BITS-1:0]   result_pix;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 9; i++)
        begin
            sum = sum + SUM_W'(s3_prod_reg[i]);
        end
        sum_floor = SUM_W'(sum >>> imgconv3_pkg::FRAC_BITS);
        if (sum[SUM_W-1])
        begin
            result_pix = '0;
        end
        else if (sum_floor[SUM_W-1:PIXEL_BITS] != '0)
        begin
            result_pix = '1;
        end
        else
        begin
            result_pix = sum_floor[PIXEL_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // output register with one skid entry
    // ---------------------------------------------------------------------
    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] out_pix_reg;
    logic                  out_last_reg;
    logic [PIXEL_BITS-1:0] skid_pix_reg;
    logic                  skid_last_reg;
    logic                  take;
    logic                  push;

    assign take = out_valid_reg && m_axis_tready;
    assign push = advance && s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_pix_reg  <= skid_pix_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_pix_reg  <= result_pix;
                skid_last_reg <= s3_last_reg;
            end
            else
            begin
                out_pix_reg  <= result_pix;
                out_last_reg <= s3_last_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_BITS'(out_pix_reg);
    assign m_axis_tlast  = out_last_reg;

endmodule
